### design/stie_pkg.sv
// Package for the session table with idle expiry.
// Table geometry, operation and status codes, the table entry type and
// the tunnel address helper. Depends on nothing.
`default_nettype none

package stie_pkg;

   localparam int TABLE_SLOTS = 32;
   localparam int KEY_BYTES   = 8;
   localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int SLOT_W  = 5;
   localparam int KEY_W   = 64;
   localparam int ADDR_W  = 32;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 6;
   localparam int TMO_W   = 16;

   localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND_KEY  = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND_ADDR = 3'd2;
   localparam logic [OP_W-1:0] OP_RELEASE   = 3'd3;
   localparam logic [OP_W-1:0] OP_SWEEP     = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS       = 2'd1;
   localparam logic [STAT_W-1:0] ST_EXPIRED    = 2'd2;
   localparam logic [STAT_W-1:0] ST_SWEEP_DONE = 2'd3;

   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd60;

   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

   localparam logic [7:0]        ADDR_NET    = 8'd10;
   localparam logic [7:0]        ADDR_OFFSET = 8'd2;
   localparam logic [ADDR_W-1:0] ADDR_BASE   = {ADDR_NET, ADDR_NET, 8'd0, 8'd0};

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   // What the sequencer presents to the match unit for the slot in hand.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic             active;
      logic [IDX_W-1:0] idx;
   } probe_type;

   function automatic logic [ADDR_W-1:0] slot_address(input logic [IDX_W-1:0] idx);
      logic [7:0] host;
      host = 8'(ADDR_OFFSET + 8'(idx));
      return ADDR_BASE | {24'd0, host};
   endfunction

   function automatic logic [SLOT_W-1:0] slot_port(input logic [IDX_W-1:0] idx);
      return SLOT_W'(idx);
   endfunction

endpackage

`default_nettype wire

### design/stie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the session table entries; no dependencies.
`default_nettype none

module stie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/stie_match.sv
// Shared match unit: decides for one table slot whether it answers the
// current operation. Uses stie_pkg for codes, types and the address helper.
`default_nettype none

module stie_match
   import stie_pkg::*;
(
   input  wire probe_type         probe,
   input  wire entry_type         entry,
   input  wire logic [KEY_W-1:0]  key,
   input  wire logic [ADDR_W-1:0] address,
   input  wire logic [TIME_W-1:0] now,
   input  wire logic [TMO_W-1:0]  timeout,
   output logic                   hit
);

   logic [TIME_W-1:0] idle;
   logic              expired;

   // Idle time wraps modulo 2^32, as the time counter itself does.
   assign idle    = now - entry.last_seen;
   assign expired = idle > TIME_W'(timeout);

   always_comb begin
      unique case (probe.op)
         OP_ALLOC:     hit = !probe.active;
         OP_FIND_KEY:  hit = probe.active && (entry.key == key);
         OP_FIND_ADDR: hit = probe.active && (slot_address(probe.idx) == address);
         OP_SWEEP:     hit = probe.active && expired;
         default:      hit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

### design/session_table_with_idle_expiry.sv
// Session table with idle expiry: top level, sequencer and result register.
// Depends on stie_pkg, stie_ram and stie_match.
//
// Usage: an item arrives on the req_ channel (valid/stall) with an operation:
// allocate, find by key, find by address, release or expiry sweep. Results
// leave on the rsp_ channel; rsp_last_result marks the final one of an item.
// The idle timeout is written through csr_wr_en/csr_wr_data between items.
// Allocate and the two lookups walk the table one slot per cycle through the
// table memory's read port and the shared match unit, stopping at the first
// hit, or missing after the last slot. A sweep always walks every slot,
// sending each expired notice as it is found, and then gives its finishing
// result. Release and unknown operations go straight to the final result.
// req_stall is high from acceptance until the final result has been loaded
// into the result register; that result may wait there while the next item
// is accepted. When the receiver stalls a notice, the walk holds on that
// slot. Reset marks every slot inactive, sets the timeout to 60 and empties
// the result register; the key and time memory is not cleared, and its
// contents only count for slots marked active.
`default_nettype none

module session_table_with_idle_expiry
   import stie_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [OP_W-1:0]   req_operation,
   input  wire logic [KEY_W-1:0]  req_session_key,
   input  wire logic [ADDR_W-1:0] req_tunnel_address,
   input  wire logic [SLOT_W-1:0] req_slot_number,
   input  wire logic [TIME_W-1:0] req_now_seconds,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]      rsp_slot_index,
   output logic [ADDR_W-1:0]      rsp_address_out,
   output logic [COUNT_W-1:0]     rsp_expired_count,
   output logic                   rsp_last_result,
   input  wire logic              csr_wr_en,
   input  wire logic [TMO_W-1:0]  csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINAL
   } state_type;

   state_type              state_ff, state_in;
   logic [TABLE_SLOTS-1:0] active_ff, active_in;
   logic [TMO_W-1:0]       timeout_ff, timeout_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;

   logic [STAT_W-1:0]      pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic [ADDR_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [COUNT_W-1:0]     pend_cnt_ff, pend_cnt_in;

   logic                   rv_ff, rv_in;
   logic [STAT_W-1:0]      rstatus_ff, rstatus_in;
   logic [SLOT_W-1:0]      rslot_ff, rslot_in;
   logic [ADDR_W-1:0]      raddr_ff, raddr_in;
   logic [COUNT_W-1:0]     rcnt_ff, rcnt_in;
   logic                   rlast_ff, rlast_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   entry_type              ram_wr_data;
   entry_type              ram_rd_data;

   probe_type              probe;
   logic                   hit;
   logic                   out_free;
   logic                   last_slot;
   logic                   rel_ok;
   logic [IDX_W-1:0]       rel_idx;

   stie_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign probe.op     = op_ff;
   assign probe.active = active_ff[idx_ff];
   assign probe.idx    = idx_ff;

   stie_match u_match (
      .probe   (probe),
      .entry   (ram_rd_data),
      .key     (key_ff),
      .address (addr_ff),
      .now     (now_ff),
      .timeout (timeout_ff),
      .hit     (hit)
   );

   assign ram_wr_data.key       = key_ff;
   assign ram_wr_data.last_seen = now_ff;

   assign out_free  = !rv_ff || !rsp_stall;
   assign last_slot = (idx_ff == IDX_W'(TABLE_SLOTS - 1));
   assign rel_idx   = IDX_W'(req_slot_number);
   assign rel_ok    = (32'(req_slot_number) < TABLE_SLOTS) && active_ff[rel_idx];
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      timeout_in     = csr_wr_en ? csr_wr_data : timeout_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      addr_in        = addr_ff;
      now_in         = now_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      pend_addr_in   = pend_addr_ff;
      pend_cnt_in    = pend_cnt_ff;
      rv_in          = rv_ff && rsp_stall;
      rstatus_in     = rstatus_ff;
      rslot_in       = rslot_ff;
      raddr_in       = raddr_ff;
      rcnt_in        = rcnt_ff;
      rlast_in       = rlast_ff;
      ram_wr_en      = 1'b0;
      ram_rd_addr    = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in          = req_operation;
               key_in         = req_session_key & KEY_MASK;
               addr_in        = req_tunnel_address;
               now_in         = req_now_seconds;
               idx_in         = '0;
               cnt_in         = '0;
               ram_rd_addr    = '0;
               pend_cnt_in    = '0;
               unique case (req_operation) inside
                  OP_ALLOC, OP_FIND_KEY, OP_FIND_ADDR, OP_SWEEP: begin
                     state_in = S_SCAN;
                  end
                  OP_RELEASE: begin
                     state_in = S_FINAL;
                     if (rel_ok) begin
                        active_in[rel_idx] = 1'b0;
                        pend_status_in     = ST_OK;
                        pend_slot_in       = req_slot_number;
                        pend_addr_in       = slot_address(rel_idx);
                     end else begin
                        pend_status_in     = ST_MISS;
                        pend_slot_in       = req_slot_number;
                        pend_addr_in       = '0;
                     end
                  end
                  default: begin
                     state_in       = S_FINAL;
                     pend_status_in = ST_MISS;
                     pend_slot_in   = '0;
                     pend_addr_in   = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (op_ff == OP_SWEEP) begin
               if (hit) begin
                  // A notice waits on this slot until the result register frees.
                  if (out_free) begin
                     rv_in             = 1'b1;
                     rstatus_in        = ST_EXPIRED;
                     rslot_in          = slot_port(idx_ff);
                     raddr_in          = slot_address(idx_ff);
                     rcnt_in           = '0;
                     rlast_in          = 1'b0;
                     active_in[idx_ff] = 1'b0;
                     cnt_in            = cnt_ff + COUNT_W'(1);
                     if (last_slot) begin
                        state_in       = S_FINAL;
                        pend_status_in = ST_SWEEP_DONE;
                        pend_slot_in   = '0;
                        pend_addr_in   = '0;
                        pend_cnt_in    = cnt_ff + COUNT_W'(1);
                     end else begin
                        idx_in         = idx_ff + IDX_W'(1);
                        ram_rd_addr    = idx_ff + IDX_W'(1);
                     end
                  end
               end else if (last_slot) begin
                  state_in       = S_FINAL;
                  pend_status_in = ST_SWEEP_DONE;
                  pend_slot_in   = '0;
                  pend_addr_in   = '0;
                  pend_cnt_in    = cnt_ff;
               end else begin
                  idx_in      = idx_ff + IDX_W'(1);
                  ram_rd_addr = idx_ff + IDX_W'(1);
               end
            end else if (hit) begin
               state_in       = S_FINAL;
               pend_status_in = ST_OK;
               pend_slot_in   = slot_port(idx_ff);
               pend_addr_in   = slot_address(idx_ff);
               if (op_ff == OP_ALLOC) begin
                  active_in[idx_ff] = 1'b1;
                  ram_wr_en         = 1'b1;
               end
            end else if (last_slot) begin
               state_in       = S_FINAL;
               pend_status_in = ST_MISS;
               pend_slot_in   = '0;
               pend_addr_in   = '0;
            end else begin
               idx_in      = idx_ff + IDX_W'(1);
               ram_rd_addr = idx_ff + IDX_W'(1);
            end
         end

         S_FINAL: begin
            if (out_free) begin
               rv_in      = 1'b1;
               rstatus_in = pend_status_ff;
               rslot_in   = pend_slot_ff;
               raddr_in   = pend_addr_ff;
               rcnt_in    = pend_cnt_ff;
               rlast_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= '0;
         timeout_ff <= TIMEOUT_RESET;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         timeout_ff <= timeout_in;
         rv_ff      <= rv_in;
      end
      op_ff          <= op_in;
      key_ff         <= key_in;
      addr_ff        <= addr_in;
      now_ff         <= now_in;
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      pend_addr_ff   <= pend_addr_in;
      pend_cnt_ff    <= pend_cnt_in;
      rstatus_ff     <= rstatus_in;
      rslot_ff       <= rslot_in;
      raddr_ff       <= raddr_in;
      rcnt_ff        <= rcnt_in;
      rlast_ff       <= rlast_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rstatus_ff;
   assign rsp_slot_index    = rslot_ff;
   assign rsp_address_out   = raddr_ff;
   assign rsp_expired_count = rcnt_ff;
   assign rsp_last_result   = rlast_ff;

endmodule

`default_nettype wire

### design/stie_checker.sv
// Port-level checker for the session table with idle expiry, and its bind.
// Depends on stie_pkg for widths and status codes.
`default_nettype none

module stie_checker
   import stie_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [STAT_W-1:0]  rsp_status,
   input wire logic [SLOT_W-1:0]  rsp_slot_index,
   input wire logic [ADDR_W-1:0]  rsp_address_out,
   input wire logic [COUNT_W-1:0] rsp_expired_count,
   input wire logic               rsp_last_result
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_notice_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EXPIRED) |-> !rsp_last_result)
      else $error("expired notice marked as final item");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_SWEEP_DONE) |->
         rsp_last_result && (rsp_slot_index == '0) && (rsp_address_out == '0))
      else $error("sweep finishing item malformed");

   a_count_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_SWEEP_DONE) |-> (rsp_expired_count == '0))
      else $error("expired count on an item that does not finish a sweep");

endmodule

bind session_table_with_idle_expiry stie_checker u_stie_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_slot_index    (rsp_slot_index),
   .rsp_address_out   (rsp_address_out),
   .rsp_expired_count (rsp_expired_count),
   .rsp_last_result   (rsp_last_result)
);

`default_nettype wire

### test/session_table_checker.sv
// Checker for the session table with idle expiry: watches the request, result
// and register ports, predicts every result and compares it on arrival.
// Depends on stie_pkg for widths, operation codes and status codes.

module session_table_checker
   import stie_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [OP_W-1:0]   req_operation,
   input  wire logic [KEY_W-1:0]  req_session_key,
   input  wire logic [ADDR_W-1:0] req_tunnel_address,
   input  wire logic [SLOT_W-1:0] req_slot_number,
   input  wire logic [TIME_W-1:0] req_now_seconds,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [STAT_W-1:0] rsp_status,
   input  wire logic [SLOT_W-1:0] rsp_slot_index,
   input  wire logic [ADDR_W-1:0] rsp_address_out,
   input  wire logic [COUNT_W-1:0] rsp_expired_count,
   input  wire logic              rsp_last_result,
   input  wire logic              csr_wr_en,
   input  wire logic [TMO_W-1:0]  csr_wr_data,
   output int                     mismatch_count,
   output int                     answers_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot_index;
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] expired;
      logic               last;
   } answer_type;

   answer_type        expected_answers[$];
   logic              live[TABLE_SLOTS];
   logic [KEY_W-1:0]  stored_key[TABLE_SLOTS];
   logic [TIME_W-1:0] stored_seen[TABLE_SLOTS];
   logic [TMO_W-1:0]  idle_limit;

   // Every slot owns the host address 10.10.0.(2 + slot), wrapping in the low byte.
   function automatic logic [ADDR_W-1:0] tunnel_of(input int slot);
      return {ADDR_NET, ADDR_NET, 8'd0, 8'(ADDR_OFFSET + 8'(slot))};
   endfunction

   task automatic predict_answers(input logic [OP_W-1:0]   op,
                                  input logic [KEY_W-1:0]  key_in,
                                  input logic [ADDR_W-1:0] addr,
                                  input logic [SLOT_W-1:0] slot,
                                  input logic [TIME_W-1:0] now);
      logic [KEY_W-1:0] key;
      int               hit;
      int               freed;
      key   = key_in & KEY_MASK;
      hit   = -1;
      freed = 0;
      case (op)
         OP_ALLOC: begin
            for (int i = 0; i < TABLE_SLOTS; i++)
               if (hit < 0 && !live[i]) hit = i;
            if (hit >= 0) begin
               live[hit]        = 1'b1;
               stored_key[hit]  = key;
               stored_seen[hit] = now;
               expected_answers.push_back(
                  answer_type'{ST_OK, SLOT_W'(hit), tunnel_of(hit), '0, 1'b1});
            end else begin
               expected_answers.push_back(answer_type'{ST_MISS, '0, '0, '0, 1'b1});
            end
         end
         OP_FIND_KEY, OP_FIND_ADDR: begin
            // Only active slots take part, and the lowest match wins.
            for (int i = 0; i < TABLE_SLOTS; i++)
               if (hit < 0 && live[i] &&
                   ((op == OP_FIND_KEY) ? (stored_key[i] == key) : (tunnel_of(i) == addr)))
                  hit = i;
            if (hit >= 0)
               expected_answers.push_back(
                  answer_type'{ST_OK, SLOT_W'(hit), tunnel_of(hit), '0, 1'b1});
            else
               expected_answers.push_back(answer_type'{ST_MISS, '0, '0, '0, 1'b1});
         end
         OP_RELEASE: begin
            if (int'(slot) < TABLE_SLOTS && live[slot]) begin
               live[slot]        = 1'b0;
               stored_key[slot]  = '0;
               stored_seen[slot] = '0;
               expected_answers.push_back(
                  answer_type'{ST_OK, slot, tunnel_of(int'(slot)), '0, 1'b1});
            end else begin
               expected_answers.push_back(answer_type'{ST_MISS, slot, '0, '0, 1'b1});
            end
         end
         OP_SWEEP: begin
            // Idle time is taken modulo 2^32, so a clock that has wrapped still counts.
            for (int i = 0; i < TABLE_SLOTS; i++)
               if (live[i] && TIME_W'(now - stored_seen[i]) > TIME_W'(idle_limit)) begin
                  live[i]        = 1'b0;
                  stored_key[i]  = '0;
                  stored_seen[i] = '0;
                  freed++;
                  expected_answers.push_back(
                     answer_type'{ST_EXPIRED, SLOT_W'(i), tunnel_of(i), '0, 1'b0});
               end
            expected_answers.push_back(
               answer_type'{ST_SWEEP_DONE, '0, '0, COUNT_W'(freed), 1'b1});
         end
         default: begin
            expected_answers.push_back(answer_type'{ST_MISS, '0, '0, '0, 1'b1});
         end
      endcase
   endtask

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) live[i] = 1'b0;
         idle_limit = TIMEOUT_RESET;
         expected_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = answer_type'{rsp_status, rsp_slot_index, rsp_address_out,
                               rsp_expired_count, rsp_last_result};
            if (expected_answers.size() == 0) begin
               mismatch_count++;
               $display({"%0t: unexpected result: status %0d slot %0d address %h",
                         " count %0d last %0b"},
                        $time, got.status, got.slot_index, got.address, got.expired,
                        got.last);
            end else begin
               want = expected_answers.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display({"%0t: result mismatch: expected status %0d slot %0d",
                            " address %h count %0d last %0b, actual status %0d",
                            " slot %0d address %h count %0d last %0b"},
                           $time, want.status, want.slot_index, want.address, want.expired,
                           want.last, got.status, got.slot_index, got.address, got.expired,
                           got.last);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_answers(req_operation, req_session_key, req_tunnel_address,
                            req_slot_number, req_now_seconds);
         if (csr_wr_en)
            idle_limit = csr_wr_data;
      end
      answers_due = expected_answers.size();
   end

endmodule

### test/tb_top.sv
// Top of the session table testbench: clock, reset, item stimulus, receiver
// stalls, idle timeout writes and the verdict.
// Depends on stie_pkg, session_table_with_idle_expiry and session_table_checker.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import stie_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_SWEEP + 1'b1;

   logic              clock;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation      = '0;
   logic [KEY_W-1:0]  req_session_key    = '0;
   logic [ADDR_W-1:0] req_tunnel_address = '0;
   logic [SLOT_W-1:0] req_slot_number    = '0;
   logic [TIME_W-1:0] req_now_seconds    = '0;
   logic              rsp_valid;
   logic              rsp_stall          = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic [ADDR_W-1:0] rsp_address_out;
   logic [COUNT_W-1:0] rsp_expired_count;
   logic              rsp_last_result;
   logic              csr_wr_en          = 1'b0;
   logic [TMO_W-1:0]  csr_wr_data        = '0;

   int                mismatch_count;
   int                answers_due;
   int                cycle_count        = 0;

   logic              calm               = 1'b0;
   logic              hold_req           = 1'b0;
   logic [TMO_W-1:0]  tmo_now            = TIMEOUT_RESET;
   logic [TIME_W-1:0] time_now           = '0;
   logic [KEY_W-1:0]  key_pool[8];

   session_table_with_idle_expiry dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_session_key    (req_session_key),
      .req_tunnel_address (req_tunnel_address),
      .req_slot_number    (req_slot_number),
      .req_now_seconds    (req_now_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_address_out    (rsp_address_out),
      .rsp_expired_count  (rsp_expired_count),
      .rsp_last_result    (rsp_last_result),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   session_table_checker table_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_session_key    (req_session_key),
      .req_tunnel_address (req_tunnel_address),
      .req_slot_number    (req_slot_number),
      .req_now_seconds    (req_now_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_address_out    (rsp_address_out),
      .rsp_expired_count  (rsp_expired_count),
      .rsp_last_result    (rsp_last_result),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .answers_due        (answers_due)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Receiver: random stalls, none while calm, and one long hold on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 27);
      end
   end

   // Offers one item from a falling edge and returns at the falling edge after
   // it has been taken.
   task automatic send_item(input logic [OP_W-1:0]   op,
                            input logic [KEY_W-1:0]  key,
                            input logic [ADDR_W-1:0] addr,
                            input logic [SLOT_W-1:0] slot,
                            input logic [TIME_W-1:0] now);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_session_key    <= key;
      req_tunnel_address <= addr;
      req_slot_number    <= slot;
      req_now_seconds    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_due != 0) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [TMO_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tmo_now = value;
   endtask

   // Weights are percentages; whatever is left over goes to the unused codes.
   task automatic random_item(input int w_alloc, input int w_key, input int w_addr,
                              input int w_rel, input int w_sweep);
      int                roll;
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] addr;
      roll = $urandom_range(99);
      if (roll < w_alloc)
         op = OP_ALLOC;
      else if (roll < w_alloc + w_key)
         op = OP_FIND_KEY;
      else if (roll < w_alloc + w_key + w_addr)
         op = OP_FIND_ADDR;
      else if (roll < w_alloc + w_key + w_addr + w_rel)
         op = OP_RELEASE;
      else if (roll < w_alloc + w_key + w_addr + w_rel + w_sweep)
         op = OP_SWEEP;
      else
         op = OP_UNUSED_FIRST + OP_W'($urandom_range(2));

      case ($urandom_range(7))
         0:       key = '0;
         1:       key = '1;
         2, 3:    key = key_pool[$urandom_range(7)];
         default: key = {$urandom, $urandom};
      endcase
      // Lookups by key mostly ask for one that has been handed out.
      if (op == OP_FIND_KEY && $urandom_range(3) != 0)
         key = key_pool[$urandom_range(7)];
      if (op == OP_ALLOC)
         key_pool[$urandom_range(7)] = key;

      case ($urandom_range(9))
         0:       addr = $urandom;
         1:       addr = ADDR_BASE | ADDR_W'($urandom_range(255));
         default: addr = ADDR_BASE + ADDR_W'(ADDR_OFFSET) + ADDR_W'($urandom_range(TABLE_SLOTS - 1));
      endcase

      time_now = time_now + TIME_W'($urandom_range(int'(tmo_now) / 8 + 1));
      if (op == OP_SWEEP && $urandom_range(2) == 0)
         time_now = time_now + TIME_W'(tmo_now) + TIME_W'($urandom_range(2));

      send_item(op, key, addr, SLOT_W'($urandom_range(TABLE_SLOTS - 1)), time_now);
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, first with the timeout at its reset value, then at zero.
      send_item(OP_FIND_KEY, '0, $urandom, SLOT_W'($urandom), $urandom);
      send_item(OP_FIND_ADDR, {$urandom, $urandom}, ADDR_BASE + ADDR_W'(ADDR_OFFSET),
                SLOT_W'($urandom), $urandom);
      send_item(OP_RELEASE, {$urandom, $urandom}, $urandom, '0, $urandom);
      send_item(OP_RELEASE, {$urandom, $urandom}, $urandom, '1, $urandom);
      send_item(OP_SWEEP, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), '1);
      send_item(OP_ALLOC, '1, $urandom, SLOT_W'($urandom), 32'hFFFF_FFF0);
      send_item(OP_ALLOC, '0, $urandom, SLOT_W'($urandom), '0);
      send_item(OP_ALLOC, '1, $urandom, SLOT_W'($urandom), 32'd100);
      send_item(OP_FIND_KEY, '1, $urandom, SLOT_W'($urandom), $urandom);
      send_item(OP_FIND_ADDR, {$urandom, $urandom}, ADDR_BASE + ADDR_W'(ADDR_OFFSET) + 1,
                SLOT_W'($urandom), $urandom);
      send_item(OP_FIND_ADDR, {$urandom, $urandom}, ADDR_BASE + ADDR_W'(ADDR_OFFSET),
                SLOT_W'($urandom), $urandom);
      send_item(OP_FIND_ADDR, {$urandom, $urandom},
                ADDR_BASE + ADDR_W'(ADDR_OFFSET) + ADDR_W'(TABLE_SLOTS - 1),
                SLOT_W'($urandom), $urandom);
      send_item(OP_FIND_ADDR, {$urandom, $urandom}, '1, SLOT_W'($urandom), $urandom);
      send_item(OP_RELEASE, {$urandom, $urandom}, $urandom, '0, $urandom);
      // With the first copy released, the duplicate key is found in a higher slot.
      send_item(OP_FIND_KEY, '1, $urandom, SLOT_W'($urandom), $urandom);
      send_item(OP_RELEASE, {$urandom, $urandom}, $urandom, '0, $urandom);
      for (int u = 0; u < 3; u++)
         send_item(OP_UNUSED_FIRST + OP_W'(u), {$urandom, $urandom}, $urandom,
                   SLOT_W'($urandom), $urandom);
      // An activity time later than the sweep time wraps to a huge idle time.
      send_item(OP_SWEEP, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), 32'd60);
      send_item(OP_SWEEP, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), 32'd61);
      write_timeout('0);
      send_item(OP_ALLOC, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), 32'd1000);
      send_item(OP_SWEEP, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), 32'd1000);
      send_item(OP_SWEEP, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), 32'd1001);

      // Longest timeout: mostly allocations, then a full table swept empty.
      write_timeout('1);
      time_now = $urandom;
      for (int n = 0; n < 20; n++) begin
         if (n == 5) hold_req = 1'b1;
         random_item(70, 10, 10, 5, 2);
      end
      calm = 1'b1;
      repeat (TABLE_SLOTS + 1)
         send_item(OP_ALLOC, {$urandom, $urandom}, $urandom, SLOT_W'($urandom), time_now);
      send_item(OP_SWEEP, {$urandom, $urandom}, $urandom, SLOT_W'($urandom),
                time_now + TIME_W'(tmo_now) + 1);
      calm = 1'b0;

      // Timeout of one: a full mix with frequent sweeps.
      write_timeout(16'd1);
      time_now = $urandom;
      for (int n = 0; n < 26; n++)
         random_item(30, 15, 15, 15, 17);

      // Random timeout, with the clock running across its wrap.
      write_timeout(TMO_W'($urandom_range(500, 2)));
      time_now = 32'hFFFF_FFFF - TIME_W'($urandom_range(2000));
      for (int n = 0; n < 26; n++) begin
         if (n == 13) wait_drained();
         random_item(35, 15, 15, 15, 15);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && answers_due == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
